>>> sv/rpc_pkg.sv
`timescale 1ns / 1ps

package rpc_pkg;

  localparam int DEADBAND   = 30;
  localparam int NUM_LEVELS = 6;
  localparam int POS_W      = 12;
  localparam int LEVEL_W    = 3;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_SET       = 3'd1,
    OP_STEP_UP   = 3'd2,
    OP_STEP_DOWN = 3'd3,
    OP_LEVEL     = 3'd4,
    OP_STOP      = 3'd5
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESET0 = 3'd2;

  localparam logic [POS_W-1:0] MIN_RESET = 12'd0;
  localparam logic [POS_W-1:0] MAX_RESET = 12'd4095;
  localparam logic [NUM_LEVELS-1:0][POS_W-1:0] PRESET_RESET = {
    12'd3000, 12'd2500, 12'd2000, 12'd1500, 12'd1000, 12'd100
  };

  typedef struct packed {
    logic [POS_W-1:0]                  min_target;
    logic [POS_W-1:0]                  max_target;
    logic [NUM_LEVELS-1:0][POS_W-1:0]  presets;
  } cfg_t;

  typedef struct packed {
    logic [2:0]       opcode;
    logic [POS_W-1:0] operand_value;
    logic [POS_W-1:0] position_sample;
  } cmd_t;

  typedef struct packed {
    logic               drive_up;
    logic               drive_down;
    logic               reached;
    logic [POS_W-1:0]   current_target;
    logic [LEVEL_W-1:0] nearest_level;
  } result_t;

endpackage

>>> sv/rpc_cfg.sv
`timescale 1ns / 1ps

module rpc_cfg import rpc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [POS_W-1:0]     cfg_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_target <= MIN_RESET;
      cfg.max_target <= MAX_RESET;
      cfg.presets    <= PRESET_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_MIN) begin
        cfg.min_target <= cfg_data;
      end else if (cfg_index == CFG_MAX) begin
        cfg.max_target <= cfg_data;
      end else begin
        cfg.presets[LEVEL_W'(cfg_index - CFG_PRESET0)] <= cfg_data;
      end
    end
  end

endmodule

>>> sv/rpc_nearest.sv
`timescale 1ns / 1ps

module rpc_nearest import rpc_pkg::*; (
  input  logic [POS_W-1:0]                 position,
  input  logic [NUM_LEVELS-1:0][POS_W-1:0] presets,
  output logic [LEVEL_W-1:0]               level
);

  logic [NUM_LEVELS-1:0][POS_W-1:0] level_dist;
  logic [POS_W-1:0]                 best_dist;

  always_comb begin
    for (int i = 0; i < NUM_LEVELS; i++) begin
      level_dist[i] = (position >= presets[i]) ? position - presets[i]
                                               : presets[i] - position;
    end
  end

  // strict compare keeps the lowest index on a tie
  always_comb begin
    best_dist = level_dist[0];
    level     = '0;
    for (int i = 1; i < NUM_LEVELS; i++) begin
      if (level_dist[i] < best_dist) begin
        best_dist = level_dist[i];
        level     = LEVEL_W'(i);
      end
    end
  end

endmodule

>>> sv/rpc_core.sv
`timescale 1ns / 1ps

module rpc_core import rpc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  cmd_t    cmd,
  input  logic    advance,
  output result_t res,
  output logic    reached_state,
  output logic    up_state,
  output logic    down_state
);

  localparam logic signed [POS_W:0]   DB     = (POS_W+1)'(DEADBAND);
  localparam logic [LEVEL_W-1:0]      LV_MAX = LEVEL_W'(NUM_LEVELS - 1);

  logic [POS_W-1:0]          target_position;
  logic                      reached_flag;
  logic                      drive_up_line;
  logic                      drive_down_line;

  logic [POS_W-1:0]          target_position_next;
  logic                      reached_flag_next;
  logic                      drive_up_line_next;
  logic                      drive_down_line_next;

  logic [LEVEL_W-1:0]        level_idx;
  logic signed [POS_W+1:0]   raw_target;
  logic signed [POS_W+1:0]   clamp_v;
  logic signed [POS_W:0]     diff_up;
  logic signed [POS_W:0]     diff_down;
  logic [LEVEL_W-1:0]        nearest;

  assign level_idx = (cmd.operand_value > POS_W'(LV_MAX)) ? LV_MAX
                                                           : cmd.operand_value[LEVEL_W-1:0];

  always_comb begin
    case (cmd.opcode)
      OP_SET:       raw_target = $signed({2'b00, cmd.operand_value});
      OP_STEP_UP:   raw_target = $signed({2'b00, target_position}) +
                                 $signed({2'b00, cmd.operand_value});
      OP_STEP_DOWN: raw_target = $signed({2'b00, target_position}) -
                                 $signed({2'b00, cmd.operand_value});
      OP_LEVEL:     raw_target = $signed({2'b00, cfg.presets[level_idx]});
      default:      raw_target = $signed({2'b00, cmd.position_sample});
    endcase
  end

  // raise to min first, then lower to max
  always_comb begin
    clamp_v = raw_target;
    if (clamp_v < $signed({2'b00, cfg.min_target})) clamp_v = $signed({2'b00, cfg.min_target});
    if (clamp_v > $signed({2'b00, cfg.max_target})) clamp_v = $signed({2'b00, cfg.max_target});
  end

  assign diff_up   = $signed({1'b0, target_position}) - $signed({1'b0, cmd.position_sample});
  assign diff_down = $signed({1'b0, cmd.position_sample}) - $signed({1'b0, target_position});

  always_comb begin
    target_position_next = target_position;
    reached_flag_next    = reached_flag;
    drive_up_line_next   = drive_up_line;
    drive_down_line_next = drive_down_line;
    case (cmd.opcode)
      OP_TICK: begin
        if (!reached_flag) begin
          if (diff_up > DB) begin
            drive_up_line_next   = 1'b1;
            drive_down_line_next = 1'b0;
          end else if (diff_down > DB) begin
            drive_up_line_next   = 1'b0;
            drive_down_line_next = 1'b1;
          end else begin
            drive_up_line_next   = 1'b0;
            drive_down_line_next = 1'b0;
            reached_flag_next    = 1'b1;
          end
        end
      end
      OP_SET, OP_STEP_UP, OP_STEP_DOWN, OP_LEVEL: begin
        target_position_next = clamp_v[POS_W-1:0];
        reached_flag_next    = 1'b0;
      end
      OP_STOP: begin
        target_position_next = clamp_v[POS_W-1:0];
        reached_flag_next    = 1'b1;
        drive_up_line_next   = 1'b0;
        drive_down_line_next = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_position <= '0;
      reached_flag    <= 1'b1;
      drive_up_line   <= 1'b0;
      drive_down_line <= 1'b0;
    end else if (advance) begin
      target_position <= target_position_next;
      reached_flag    <= reached_flag_next;
      drive_up_line   <= drive_up_line_next;
      drive_down_line <= drive_down_line_next;
    end
  end

  rpc_nearest u_nearest (
    .position (cmd.position_sample),
    .presets  (cfg.presets),
    .level    (nearest)
  );

  assign res.drive_up       = drive_up_line_next;
  assign res.drive_down     = drive_down_line_next;
  assign res.reached        = reached_flag_next;
  assign res.current_target = target_position_next;
  assign res.nearest_level  = nearest;

  assign reached_state = reached_flag;
  assign up_state      = drive_up_line;
  assign down_state    = drive_down_line;

endmodule

>>> sv/resistance_position_controller.sv
`timescale 1ns / 1ps

// Bang-bang position controller with a deadband of 30 counts around a clamped
// target, plus a nearest-preset lookup on every position sample. Each request
// produces one result: it passes through the input register, then through the
// target/clamp/drive logic into the result register. A new request is taken
// every cycle unless the output stalls; the core state is updated in the same
// cycle as the result register is loaded. The configuration port is always
// ready and is meant to be written only while no request is in flight.

module resistance_position_controller import rpc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [31:0]          s_tdata,   // opcode[2:0], operand_value[14:3], position_sample[26:15]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [23:0]          m_tdata,   // drive_up[0], drive_down[1], reached[2],
                                          // current_target[14:3], nearest_level[17:15]
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [POS_W-1:0]     cfg_data
);

  cfg_t    cfg;
  cmd_t    in_cmd;
  logic    in_valid;
  logic    advance;
  result_t res;
  result_t out_res;
  logic    out_valid;
  logic    reached_state;
  logic    up_state;
  logic    down_state;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;

  rpc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rpc_core u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (in_cmd),
    .advance       (advance),
    .res           (res),
    .reached_state (reached_state),
    .up_state      (up_state),
    .down_state    (down_state)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd.opcode          <= s_tdata[2:0];
      in_cmd.operand_value   <= s_tdata[14:3];
      in_cmd.position_sample <= s_tdata[26:15];
    end
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b000000, out_res.nearest_level, out_res.current_target,
                     out_res.reached, out_res.drive_down, out_res.drive_up};

  a_reached_drives_off: assert property (@(posedge clk) disable iff (rst)
    reached_state |-> (!up_state && !down_state))
    else $error("drive active while target marked reached");

  a_single_drive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(out_res.drive_up && out_res.drive_down))
    else $error("both drive lines active in result");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_res.nearest_level <= LEVEL_W'(NUM_LEVELS - 1)))
    else $error("nearest level out of range");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (in_valid && out_valid && !m_tready) |-> !s_tready)
    else $error("request accepted while pipeline full and stalled");

endmodule
